[rtl/ifsu_pkg.sv]
// shared types, constants and helpers for the indexed framebuffer unit
package ifsu_pkg;

	// default geometry and palette size
	localparam int DEF_SCREEN_WIDTH    = 320;
	localparam int DEF_SCREEN_HEIGHT   = 240;
	localparam int DEF_PALETTE_ENTRIES = 256;

	// fixed field widths
	localparam int COORD_W = 16;
	localparam int INDEX_W = 8;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int RGB565_W = 16;

	// operation codes
	localparam logic [1:0] FUNC_FILL  = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_SETPAL = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// request payload
	typedef struct packed {
		logic [1:0]                func;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] rect_width;
		logic signed [COORD_W-1:0] rect_height;
		logic [INDEX_W-1:0]        color_index;
		logic [CHAN_W-1:0]         red;
		logic [CHAN_W-1:0]         green;
		logic [CHAN_W-1:0]         blue;
	} cmd_t;

	// result payload
	typedef struct packed {
		logic [RGB565_W-1:0] pixel_rgb565;
		logic                off_screen;
	} rsp_t;

	// start command from the controller to the raster sequencer
	typedef struct packed {
		logic                      start;
		logic                      clear;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] rect_width;
		logic signed [COORD_W-1:0] rect_height;
		logic [INDEX_W-1:0]        color_index;
	} ras_cmd_t;

	// truncate a 24-bit color (red high) to rgb565
	function automatic logic [RGB565_W-1:0] to_rgb565(input logic [COLOR_W-1:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

[rtl/ifsu_stream_if.sv]
// valid/ready channel carrying one payload
interface ifsu_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/indexed_framebuffer_fill_scanout_unit.sv]
// top level: request decode, pixel read path and result register
// read pixel: on screen, address, frame read, palette read, then result register;
//   off screen, result register only; next request taken once the result is stored
// fill: the clipped area, one pixel written per cycle
// clear: request's index over all width*height pixels; set palette entry: on accept
// reset: palette valid bits cleared at once; a clearing pass writes index 0 over
//   all width*height pixels before the first request
module indexed_framebuffer_fill_scanout_unit #(
	parameter int SCREEN_WIDTH    = ifsu_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT   = ifsu_pkg::DEF_SCREEN_HEIGHT,
	parameter int PALETTE_ENTRIES = ifsu_pkg::DEF_PALETTE_ENTRIES
) (
	input logic          clk,
	input logic          arst_n,
	ifsu_stream_if.sink   cmd,
	ifsu_stream_if.source rsp
);
	import ifsu_pkg::*;

	localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = (NPIX > 1) ? $clog2(NPIX) : 1;
	localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int PW = $clog2(PALETTE_ENTRIES);

	localparam logic [2:0] ST_BOOT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_BUSY     = 3'd2;
	localparam logic [2:0] ST_RD_ADDR  = 3'd3;
	localparam logic [2:0] ST_RD_FRAME = 3'd4;
	localparam logic [2:0] ST_RD_PAL   = 3'd5;
	localparam logic [2:0] ST_RD_OUT   = 3'd6;

	logic [2:0]          state_q;
	logic [XW-1:0]       rd_x_q;
	logic [YW-1:0]       rd_y_q;
	logic [AW-1:0]       rd_addr_q;
	logic                offs_q;
	logic                in_pal_q;
	logic                out_valid_q;
	logic [RGB565_W-1:0] out_pix_q;
	logic                out_offs_q;

	cmd_t                req;
	logic                accept;
	logic                rd_off;
	logic                out_free;
	ras_cmd_t            ras_cmd;
	logic                ras_idle;
	logic                fb_we;
	logic [AW-1:0]       fb_waddr;
	logic [INDEX_W-1:0]  fb_wdata;
	logic [INDEX_W-1:0]  fb_rdata;
	logic [COLOR_W-1:0]  pal_rdata;
	logic                pal_we;

	assign req       = cmd.payload;
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// off-screen test of the read position
	assign rd_off = req.pos_x[15] || req.pos_y[15] ||
		(req.pos_x >= 16'(SCREEN_WIDTH)) || (req.pos_y >= 16'(SCREEN_HEIGHT));

	// palette write for an in-range entry
	assign pal_we = accept && (req.func == FUNC_SETPAL) &&
		({1'b0, req.color_index} < 9'(PALETTE_ENTRIES));

	// raster start: reset clearing pass, clear or fill request
	always_comb begin
		ras_cmd.start       = (state_q == ST_BOOT) ||
			(accept && (req.func == FUNC_FILL || req.func == FUNC_CLEAR));
		ras_cmd.clear       = (state_q == ST_BOOT) || (req.func == FUNC_CLEAR);
		ras_cmd.pos_x       = req.pos_x;
		ras_cmd.pos_y       = req.pos_y;
		ras_cmd.rect_width  = req.rect_width;
		ras_cmd.rect_height = req.rect_height;
		ras_cmd.color_index = (state_q == ST_BOOT) ? '0 : req.color_index;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
		end else begin
			case (state_q)
				ST_BOOT: state_q <= ST_BUSY;
				ST_IDLE: begin
					if (accept) begin
						case (req.func)
							FUNC_FILL:   state_q <= ST_BUSY;
							FUNC_CLEAR:  state_q <= ST_BUSY;
							FUNC_SETPAL: state_q <= ST_IDLE;
							FUNC_READ:   state_q <= rd_off ? ST_RD_OUT : ST_RD_ADDR;
							default:     state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BUSY: begin
					if (ras_idle) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ADDR:  state_q <= ST_RD_FRAME;
				ST_RD_FRAME: state_q <= ST_RD_PAL;
				ST_RD_PAL:   state_q <= ST_RD_OUT;
				ST_RD_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read path registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_x_q <= req.pos_x[XW-1:0];
			rd_y_q <= req.pos_y[YW-1:0];
			offs_q <= rd_off;
		end
		if (state_q == ST_RD_ADDR) begin
			rd_addr_q <= AW'(rd_y_q * SCREEN_WIDTH) + AW'(rd_x_q);
		end
		if (state_q == ST_RD_PAL) begin
			in_pal_q <= ({1'b0, fb_rdata} < 9'(PALETTE_ENTRIES));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RD_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_OUT && out_free) begin
			out_offs_q <= offs_q;
			out_pix_q  <= (offs_q || !in_pal_q) ? '0 : to_rgb565(pal_rdata);
		end
	end

	assign rsp.valid                = out_valid_q;
	assign rsp.payload.pixel_rgb565 = out_pix_q;
	assign rsp.payload.off_screen   = out_offs_q;

	// fill and clear sequencer
	ifsu_raster #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.AW            (AW)
	) u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ras_cmd),
		.idle   (ras_idle),
		.we     (fb_we),
		.waddr  (fb_waddr),
		.wdata  (fb_wdata)
	);

	// framebuffer
	ifsu_frame_ram #(
		.DEPTH (NPIX),
		.AW    (AW)
	) u_frame (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.re    (state_q == ST_RD_FRAME),
		.raddr (rd_addr_q),
		.rdata (fb_rdata)
	);

	// palette
	ifsu_palette #(
		.ENTRIES (PALETTE_ENTRIES),
		.PW      (PW)
	) u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (pal_we),
		.waddr  (req.color_index[PW-1:0]),
		.wdata  ({req.red, req.green, req.blue}),
		.re     (state_q == ST_RD_PAL),
		.raddr  (fb_rdata[PW-1:0]),
		.rdata  (pal_rdata)
	);

	// no request taken while a sweep is running
	assert property (@(posedge clk) disable iff (!arst_n) cmd.ready |-> ras_idle)
		else $error("request ready while raster sweep active");

	// framebuffer writes only while the controller waits on the sweep
	assert property (@(posedge clk) disable iff (!arst_n) fb_we |-> state_q == ST_BUSY)
		else $error("framebuffer write outside a sweep");

	// a result appears only from the read output step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RD_OUT)
		else $error("result produced outside a pixel read");

	// an off-screen result always has a zero color
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_OUT && out_free && offs_q) |=> out_pix_q == '0)
		else $error("off-screen read with nonzero color");
endmodule

[rtl/ifsu_frame_ram.sv]
// framebuffer index memory, one write and one registered read port
module ifsu_frame_ram #(
	parameter int DEPTH = ifsu_pkg::DEF_SCREEN_WIDTH * ifsu_pkg::DEF_SCREEN_HEIGHT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ifsu_pkg::INDEX_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [ifsu_pkg::INDEX_W-1:0] rdata
);
	import ifsu_pkg::*;

	logic [INDEX_W-1:0] mem_q [DEPTH];
	logic [INDEX_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/ifsu_palette.sv]
// palette memory with per-entry valid bits, unwritten entries read as zero
module ifsu_palette #(
	parameter int ENTRIES = ifsu_pkg::DEF_PALETTE_ENTRIES,
	parameter int PW      = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [PW-1:0]                waddr,
	input  logic [ifsu_pkg::COLOR_W-1:0] wdata,
	input  logic                         re,
	input  logic [PW-1:0]                raddr,
	output logic [ifsu_pkg::COLOR_W-1:0] rdata
);
	import ifsu_pkg::*;

	logic [COLOR_W-1:0] mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [COLOR_W-1:0] rdata_q;
	logic               rvalid_q;

	// color storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;
endmodule

[rtl/ifsu_raster.sv]
// rectangle clip and write-address sequencer for fill and clear sweeps
module ifsu_raster #(
	parameter int SCREEN_WIDTH  = ifsu_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = ifsu_pkg::DEF_SCREEN_HEIGHT,
	parameter int AW = (SCREEN_WIDTH * SCREEN_HEIGHT > 1) ?
		$clog2(SCREEN_WIDTH * SCREEN_HEIGHT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ifsu_pkg::ras_cmd_t           cmd,
	output logic                         idle,
	output logic                         we,
	output logic [AW-1:0]                waddr,
	output logic [ifsu_pkg::INDEX_W-1:0] wdata
);
	import ifsu_pkg::*;

	localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam logic signed [16:0] WS = 17'(SCREEN_WIDTH);
	localparam logic signed [16:0] HS = 17'(SCREEN_HEIGHT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_WIDTH);

	localparam logic [1:0] R_IDLE  = 2'd0;
	localparam logic [1:0] R_BASE  = 2'd1;
	localparam logic [1:0] R_FILL  = 2'd2;
	localparam logic [1:0] R_CLEAR = 2'd3;

	logic [1:0]         state_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      row_q;
	logic [INDEX_W-1:0] data_q;
	logic [XW-1:0]      x0_q, xl_q, cx_q;
	logic [YW-1:0]      y0_q, yl_q, cy_q;
	logic               empty_q;

	logic signed [16:0] xs, xe, x0s, x1s, xls;
	logic signed [16:0] ys, ye, y0s, y1s, yls;
	logic               empty;
	logic [AW-1:0]      base;

	// clip the rectangle against the screen
	always_comb begin
		xs  = {cmd.pos_x[15], cmd.pos_x};
		xe  = xs + {cmd.rect_width[15], cmd.rect_width};
		x0s = xs[16] ? '0 : xs;
		x1s = (xe > WS) ? WS : xe;
		xls = x1s - 17'sd1;
		ys  = {cmd.pos_y[15], cmd.pos_y};
		ye  = ys + {cmd.rect_height[15], cmd.rect_height};
		y0s = ys[16] ? '0 : ys;
		y1s = (ye > HS) ? HS : ye;
		yls = y1s - 17'sd1;
		empty = (x1s <= x0s) || (y1s <= y0s);
	end

	// first covered pixel
	assign base = AW'(y0_q * SCREEN_WIDTH) + AW'(x0_q);

	// sweep sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (cmd.start) begin
						state_q <= cmd.clear ? R_CLEAR : R_BASE;
					end
				end
				R_BASE: begin
					state_q <= empty_q ? R_IDLE : R_FILL;
				end
				R_FILL: begin
					if (cx_q == xl_q && cy_q == yl_q) begin
						state_q <= R_IDLE;
					end
				end
				R_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// address and extent registers
	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				addr_q  <= '0;
				data_q  <= cmd.color_index;
				x0_q    <= x0s[XW-1:0];
				xl_q    <= xls[XW-1:0];
				y0_q    <= y0s[YW-1:0];
				yl_q    <= yls[YW-1:0];
				empty_q <= empty;
			end
			R_BASE: begin
				row_q  <= base;
				addr_q <= base;
				cx_q   <= x0_q;
				cy_q   <= y0_q;
			end
			R_FILL: begin
				if (cx_q == xl_q) begin
					cx_q   <= x0_q;
					cy_q   <= cy_q + 1'b1;
					row_q  <= row_q + ROW_STEP;
					addr_q <= row_q + ROW_STEP;
				end else begin
					cx_q   <= cx_q + 1'b1;
					addr_q <= addr_q + 1'b1;
				end
			end
			R_CLEAR: begin
				addr_q <= addr_q + 1'b1;
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

	assign idle  = (state_q == R_IDLE);
	assign we    = (state_q == R_FILL) || (state_q == R_CLEAR);
	assign waddr = addr_q;
	assign wdata = data_q;
endmodule
